// ===== sv/pse_pkg.sv =====
// ----------------------------------------------------------------------------
// pse_pkg: shared types and constants of the postfix stack evaluator
// Symbol codes, status codes, sequencer states and the control types that
// pass between the stack cells, the arithmetic unit and the top level.
// ----------------------------------------------------------------------------
package pse_pkg;

	// Default sizes handed to the top level parameters.
	localparam int DEF_STACK_DEPTH = 128;
	localparam int DEF_VALUE_WIDTH = 16;

	// Expression characters.
	localparam logic [7:0] SYM_ZERO  = 8'h30;
	localparam logic [7:0] SYM_NINE  = 8'h39;
	localparam logic [7:0] SYM_PLUS  = 8'h2B;
	localparam logic [7:0] SYM_MINUS = 8'h2D;
	localparam logic [7:0] SYM_STAR  = 8'h2A;
	localparam logic [7:0] SYM_SLASH = 8'h2F;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2,
		ST_DIVZERO   = 2'd3
	} status_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_DECODE,
		S_ALU,
		S_COMMIT
	} state_t;

	// What one stack cell does at the next edge.
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_LOAD_UPPER,
		CELL_LOAD_LOWER
	} cell_op_t;

	// Pending change to the stack, applied when the result is delivered.
	typedef enum logic [1:0] {
		ACT_NONE,
		ACT_PUSH,
		ACT_REPLACE,
		ACT_CLEAR
	} stack_act_t;

	// Request to the iterative arithmetic unit.
	typedef struct packed {
		logic start;
		logic is_div;
	} alu_req_t;

endpackage

// ===== sv/pse_cell.sv =====
// ----------------------------------------------------------------------------
// pse_cell: one entry of the shifting value stack
// Loads from the neighbor above on a push, from the neighbor below on a pop,
// or keeps its value.
// ----------------------------------------------------------------------------
module pse_cell #(
	parameter int VALUE_WIDTH = pse_pkg::DEF_VALUE_WIDTH
) (
	input  logic                   clk,
	input  pse_pkg::cell_op_t      op,
	input  logic [VALUE_WIDTH-1:0] upper_in,
	input  logic [VALUE_WIDTH-1:0] lower_in,
	output logic [VALUE_WIDTH-1:0] value
);
	import pse_pkg::*;

	logic [VALUE_WIDTH-1:0] value_q;

	// Entry register; contents are only meaningful below the stack depth.
	always_ff @(posedge clk) begin
		case (op)
			CELL_LOAD_UPPER: value_q <= upper_in;
			CELL_LOAD_LOWER: value_q <= lower_in;
			default:         value_q <= value_q;
		endcase
	end

	assign value = value_q;

endmodule

// ===== sv/pse_alu.sv =====
// ----------------------------------------------------------------------------
// pse_alu: iterative multiplier and divider
// Shift-and-add multiply keeping the low word, and restoring division on
// magnitudes with truncation toward zero; one bit per cycle.
// ----------------------------------------------------------------------------
module pse_alu #(
	parameter int VALUE_WIDTH = pse_pkg::DEF_VALUE_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pse_pkg::alu_req_t      req,
	input  logic [VALUE_WIDTH-1:0] lhs,
	input  logic [VALUE_WIDTH-1:0] rhs,
	output logic                   done,
	output logic [VALUE_WIDTH-1:0] result
);
	import pse_pkg::*;

	localparam int CNT_W = $clog2(VALUE_WIDTH);

	logic                   busy_q;
	logic                   done_q;
	logic                   is_div_q;
	logic                   neg_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [VALUE_WIDTH-1:0] a_q;
	logic [VALUE_WIDTH-1:0] b_q;
	logic [VALUE_WIDTH-1:0] acc_q;

	logic [VALUE_WIDTH-1:0] lhs_mag;
	logic [VALUE_WIDTH-1:0] rhs_mag;
	logic [VALUE_WIDTH-1:0] rem_shift;
	logic                   rem_fits;

	// Magnitudes of the operands for division.
	assign lhs_mag = lhs[VALUE_WIDTH-1] ? (~lhs + 1'b1) : lhs;
	assign rhs_mag = rhs[VALUE_WIDTH-1] ? (~rhs + 1'b1) : rhs;

	// The partial remainder stays below the divisor, so its top bit is free.
	assign rem_shift = {acc_q[VALUE_WIDTH-2:0], a_q[VALUE_WIDTH-1]};
	assign rem_fits  = (rem_shift >= b_q);

	// Control of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !req.start && (cnt_q == CNT_W'(VALUE_WIDTH - 1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(VALUE_WIDTH - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Datapath: one product or quotient bit per cycle.
	always_ff @(posedge clk) begin
		if (req.start) begin
			is_div_q <= req.is_div;
			neg_q    <= lhs[VALUE_WIDTH-1] ^ rhs[VALUE_WIDTH-1];
			acc_q    <= '0;
			if (req.is_div) begin
				a_q <= lhs_mag;
				b_q <= rhs_mag;
			end else begin
				a_q <= rhs;
				b_q <= lhs;
			end
		end else if (busy_q) begin
			if (is_div_q) begin
				acc_q <= rem_fits ? (rem_shift - b_q) : rem_shift;
				a_q   <= {a_q[VALUE_WIDTH-2:0], rem_fits};
			end else begin
				if (a_q[0]) begin
					acc_q <= acc_q + b_q;
				end
				a_q <= a_q >> 1;
				b_q <= b_q << 1;
			end
		end
	end

	assign done   = done_q;
	assign result = is_div_q ? (neg_q ? (~a_q + 1'b1) : a_q) : acc_q;

endmodule

// ===== sv/postfix_stack_evaluator_core.sv =====
// Sequence: each item is captured, decoded and committed to the output
// register; a valid multiply or divide runs the bit-serial unit between
// decode and commit. A new item is taken only after the last one has been
// committed; a held result delays only the commit of the next item. Reset:
// arst_n clears the sequencer, the depth and the output valid; the stack
// cells themselves are not cleared.
// ----------------------------------------------------------------------------
// postfix_stack_evaluator_core: postfix expression evaluator on a value stack
// Characters push digits, apply + - * / to the two top entries, or end the
// expression and emit the answer. The stack is a row of shifting cells with
// the top entry in cell 0.
// ----------------------------------------------------------------------------
module postfix_stack_evaluator_core #(
	parameter int STACK_DEPTH = pse_pkg::DEF_STACK_DEPTH,
	parameter int VALUE_WIDTH = pse_pkg::DEF_VALUE_WIDTH,
	parameter int DEPTH_W     = $clog2(STACK_DEPTH + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    symbol,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    status,
	output logic                          answer_valid,
	output logic signed [VALUE_WIDTH-1:0] answer,
	output logic [DEPTH_W-1:0]            depth
);
	import pse_pkg::*;

	state_t state_q, state_nxt;

	logic [7:0]             symbol_q;
	logic [DEPTH_W-1:0]     depth_q;
	status_t                pend_status_q;
	stack_act_t             pend_act_q;
	logic [VALUE_WIDTH-1:0] pend_value_q;

	logic                   out_valid_q;
	status_t                status_q;
	logic                   answer_valid_q;
	logic [VALUE_WIDTH-1:0] answer_q;
	logic [DEPTH_W-1:0]     depth_out_q;

	logic [VALUE_WIDTH-1:0] cell_val [STACK_DEPTH];
	cell_op_t               op_top;
	cell_op_t               op_rest;

	alu_req_t               alu_req;
	logic                   alu_done;
	logic [VALUE_WIDTH-1:0] alu_result;

	logic                   commit;
	logic                   out_free;
	logic                   is_digit;
	logic                   is_arith;
	logic                   is_muldiv;
	logic [VALUE_WIDTH-1:0] rhs_val;
	logic [VALUE_WIDTH-1:0] lhs_val;
	logic [7:0]             digit;

	// Symbol classification and operands from the two top cells.
	assign is_digit  = (symbol_q >= SYM_ZERO) && (symbol_q <= SYM_NINE);
	assign is_muldiv = (symbol_q == SYM_STAR) || (symbol_q == SYM_SLASH);
	assign is_arith  = is_muldiv || (symbol_q == SYM_PLUS) || (symbol_q == SYM_MINUS);
	assign rhs_val   = cell_val[0];
	assign lhs_val   = cell_val[1];
	assign digit     = symbol_q - SYM_ZERO;
	assign out_free  = !out_valid_q || !out_stall;

	// Next state.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_nxt = S_DECODE;
				end
			end
			S_DECODE: begin
				if (is_arith && (depth_q >= DEPTH_W'(2)) && is_muldiv &&
				    !((symbol_q == SYM_SLASH) && (rhs_val == '0))) begin
					state_nxt = S_ALU;
				end else begin
					state_nxt = S_COMMIT;
				end
			end
			S_ALU: begin
				if (alu_done) begin
					state_nxt = S_COMMIT;
				end
			end
			S_COMMIT: begin
				if (out_free) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		in_stall       = 1'b1;
		commit         = 1'b0;
		alu_req.start  = 1'b0;
		alu_req.is_div = (symbol_q == SYM_SLASH);
		case (state_q)
			S_IDLE:   in_stall = 1'b0;
			S_DECODE: alu_req.start = (state_nxt == S_ALU);
			S_COMMIT: commit = out_free;
			default:  in_stall = 1'b1;
		endcase
	end

	// Cell controls for the pending stack change.
	always_comb begin
		op_top  = CELL_HOLD;
		op_rest = CELL_HOLD;
		if (commit) begin
			case (pend_act_q)
				ACT_PUSH: begin
					op_top  = CELL_LOAD_UPPER;
					op_rest = CELL_LOAD_UPPER;
				end
				ACT_REPLACE: begin
					op_top  = CELL_LOAD_UPPER;
					op_rest = CELL_LOAD_LOWER;
				end
				default: begin
					op_top  = CELL_HOLD;
					op_rest = CELL_HOLD;
				end
			endcase
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			depth_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (commit) begin
				out_valid_q <= 1'b1;
				case (pend_act_q)
					ACT_PUSH:    depth_q <= depth_q + 1'b1;
					ACT_REPLACE: depth_q <= depth_q - 1'b1;
					ACT_CLEAR:   depth_q <= '0;
					default:     depth_q <= depth_q;
				endcase
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Input capture, decode of the pending result, and the output register.
	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && in_valid) begin
			symbol_q <= symbol;
		end
		if (state_q == S_DECODE) begin
			pend_status_q <= ST_OK;
			pend_act_q    <= ACT_NONE;
			pend_value_q  <= '0;
			if (is_digit) begin
				if (depth_q == DEPTH_W'(STACK_DEPTH)) begin
					pend_status_q <= ST_OVERFLOW;
				end else begin
					pend_act_q   <= ACT_PUSH;
					pend_value_q <= {{(VALUE_WIDTH-4){1'b0}}, digit[3:0]};
				end
			end else if (is_arith) begin
				if (depth_q < DEPTH_W'(2)) begin
					pend_status_q <= ST_UNDERFLOW;
				end else if ((symbol_q == SYM_SLASH) && (rhs_val == '0)) begin
					pend_status_q <= ST_DIVZERO;
				end else begin
					pend_act_q   <= ACT_REPLACE;
					pend_value_q <= (symbol_q == SYM_PLUS) ? (lhs_val + rhs_val)
					                                       : (lhs_val - rhs_val);
				end
			end else begin
				if (depth_q == '0) begin
					pend_status_q <= ST_UNDERFLOW;
				end else begin
					pend_act_q   <= ACT_CLEAR;
					pend_value_q <= rhs_val;
				end
			end
		end
		if ((state_q == S_ALU) && alu_done) begin
			pend_value_q <= alu_result;
		end
		if (commit) begin
			status_q       <= pend_status_q;
			answer_valid_q <= (pend_act_q == ACT_CLEAR);
			answer_q       <= (pend_act_q == ACT_CLEAR) ? pend_value_q : '0;
			case (pend_act_q)
				ACT_PUSH:    depth_out_q <= depth_q + 1'b1;
				ACT_REPLACE: depth_out_q <= depth_q - 1'b1;
				ACT_CLEAR:   depth_out_q <= '0;
				default:     depth_out_q <= depth_q;
			endcase
		end
	end

	// Row of stack cells; each takes from its neighbors.
	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		pse_cell #(
			.VALUE_WIDTH(VALUE_WIDTH)
		) u_cell (
			.clk      (clk),
			.op       ((i == 0) ? op_top : op_rest),
			.upper_in ((i == 0) ? pend_value_q : cell_val[(i == 0) ? 0 : i - 1]),
			.lower_in (cell_val[(i == STACK_DEPTH - 1) ? i : i + 1]),
			.value    (cell_val[i])
		);
	end

	// Shared bit-serial multiply and divide.
	pse_alu #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.lhs    (lhs_val),
		.rhs    (rhs_val),
		.done   (alu_done),
		.result (alu_result)
	);

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign answer_valid = answer_valid_q;
	assign answer       = answer_q;
	assign depth        = depth_out_q;

endmodule
